// File: src/joystick_drive_shaper_defines.svh
// Assertion macros used by the checker file.
`ifndef JOYSTICK_DRIVE_SHAPER_DEFINES_SVH
`define JOYSTICK_DRIVE_SHAPER_DEFINES_SVH

// Concurrent check, switched off while reset is high.
`define JDS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jds check failed");

// Concurrent check that also holds across reset.
`define JDS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("jds check failed");

`endif

// File: src/jds_pkg.sv
package jds_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_FORWARD      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_TURN         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FORWARD_STEP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TURN_STEP    = 3'd4;

endpackage

// File: src/jds_req_if.sv
interface jds_req_if import jds_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] forward_stick;
   logic signed [SAMPLE_BITS-1:0] twist_stick;
   logic                          restart;

   modport source (output valid, output forward_stick, output twist_stick,
                   output restart, input ready);
   modport sink   (input valid, input forward_stick, input twist_stick,
                   input restart, output ready);
endinterface

// File: src/jds_rsp_if.sv
interface jds_rsp_if import jds_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] forward_drive;
   logic signed [SAMPLE_BITS-1:0] turn_drive;

   modport source (output valid, output forward_drive, output turn_drive,
                   input ready);
   modport sink   (input valid, input forward_drive, input turn_drive,
                   output ready);
endinterface

// File: src/joystick_drive_shaper.sv
// Joystick drive shaper: turns forward and twist stick samples (signed Q1.F,
// F = SAMPLE_BITS-1) into forward and turning drive commands.
// req_ch carries one stick sample per transfer; rsp_ch returns exactly one
// drive result per sample, in order. The csr_ port writes the deadband,
// axis minimums and slew steps; write only while no sample is in flight.
// Per axis: twist negated (saturating), signed square with its magnitude rounded half up,
// deadband and minimum, then slew limit against the previous output.
// restart makes both previous outputs count as zero for that sample.
// A sample passes through the input register, one shaping pass with one
// multiplier per axis, and the result register before it reaches rsp_ch.
// Throughput: one sample per cycle unless rsp_ch stalls; the slew state is
// updated as the result register loads, so the next sample sees it directly.
// Reset clears both pipeline stages, the previous outputs (to zero) and
// loads the register defaults. While rsp_ch stalls, the result holds and one
// further sample is still taken into the input register; req_ch.ready then
// drops until the result is transferred.
module joystick_drive_shaper import jds_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   jds_req_if.sink                   req_ch,
   jds_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-2:0]    csr_wdata
);
   localparam int W    = SAMPLE_BITS;
   localparam int FRAC = SAMPLE_BITS - 1;
   localparam logic [63:0] ONE_Q     = 64'd1 << FRAC;
   localparam logic [63:0] DB_RST    = (64'd3 * ONE_Q + 64'd50) / 64'd100;
   localparam logic [63:0] FSTEP_RST = (64'd45 * ONE_Q + 64'd500) / 64'd1000;
   localparam logic [63:0] TSTEP_RST = (64'd8 * ONE_Q + 64'd50) / 64'd100;

   logic [FRAC-1:0] deadband_ff, deadband_in;
   logic [FRAC-1:0] min_forward_ff, min_forward_in;
   logic [FRAC-1:0] min_turn_ff, min_turn_in;
   logic [FRAC-1:0] fwd_step_ff, fwd_step_in;
   logic [FRAC-1:0] turn_step_ff, turn_step_in;

   logic                s1_vld_ff, s1_vld_in;
   logic signed [W-1:0] s1_fwd_ff, s1_fwd_in;
   logic signed [W-1:0] s1_twist_ff, s1_twist_in;
   logic                s1_restart_ff, s1_restart_in;

   logic                out_vld_ff, out_vld_in;
   logic signed [W-1:0] out_fwd_ff, out_fwd_in;
   logic signed [W-1:0] out_turn_ff, out_turn_in;
   logic signed [W-1:0] last_fwd_ff, last_fwd_in;
   logic signed [W-1:0] last_turn_ff, last_turn_in;

   logic                accept;
   logic                advance;
   logic signed [W-1:0] twist_neg;
   logic signed [W-1:0] prev_fwd;
   logic signed [W-1:0] prev_turn;
   logic signed [W-1:0] fwd_drive;
   logic signed [W-1:0] turn_drive;

   // configuration registers
   always_comb begin
      deadband_in    = deadband_ff;
      min_forward_in = min_forward_ff;
      min_turn_in    = min_turn_ff;
      fwd_step_in    = fwd_step_ff;
      turn_step_in   = turn_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEADBAND:         deadband_in    = csr_wdata;
            CSR_MIN_FORWARD:      min_forward_in = csr_wdata;
            CSR_MIN_TURN:         min_turn_in    = csr_wdata;
            CSR_MAX_FORWARD_STEP: fwd_step_in    = csr_wdata;
            CSR_MAX_TURN_STEP:    turn_step_in   = csr_wdata;
            default:              deadband_in    = deadband_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DB_RST[FRAC-1:0];
         min_forward_ff <= '0;
         min_turn_ff    <= '0;
         fwd_step_ff    <= FSTEP_RST[FRAC-1:0];
         turn_step_ff   <= TSTEP_RST[FRAC-1:0];
      end else begin
         deadband_ff    <= deadband_in;
         min_forward_ff <= min_forward_in;
         min_turn_ff    <= min_turn_in;
         fwd_step_ff    <= fwd_step_in;
         turn_step_ff   <= turn_step_in;
      end
   end

   // handshake
   assign advance      = s1_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign s1_vld_in     = accept || (s1_vld_ff && !advance);
   assign s1_fwd_in     = accept ? req_ch.forward_stick : s1_fwd_ff;
   assign s1_twist_in   = accept ? req_ch.twist_stick : s1_twist_ff;
   assign s1_restart_in = accept ? req_ch.restart : s1_restart_ff;

   // shaping pass
   assign twist_neg = (s1_twist_ff == {1'b1, {FRAC{1'b0}}}) ?
                      $signed({1'b0, {FRAC{1'b1}}}) : -s1_twist_ff;
   assign prev_fwd  = s1_restart_ff ? '0 : last_fwd_ff;
   assign prev_turn = s1_restart_ff ? '0 : last_turn_ff;

   jds_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_fwd (
      .sample   (s1_fwd_ff),
      .prev     (prev_fwd),
      .deadband (deadband_ff),
      .minimum  (min_forward_ff),
      .step     (fwd_step_ff),
      .drive    (fwd_drive)
   );

   jds_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_turn (
      .sample   (twist_neg),
      .prev     (prev_turn),
      .deadband (deadband_ff),
      .minimum  (min_turn_ff),
      .step     (turn_step_ff),
      .drive    (turn_drive)
   );

   assign out_vld_in   = advance || (out_vld_ff && !rsp_ch.ready);
   assign out_fwd_in   = advance ? fwd_drive : out_fwd_ff;
   assign out_turn_in  = advance ? turn_drive : out_turn_ff;
   assign last_fwd_in  = advance ? fwd_drive : last_fwd_ff;
   assign last_turn_in = advance ? turn_drive : last_turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         last_fwd_ff  <= '0;
         last_turn_ff <= '0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         out_vld_ff   <= out_vld_in;
         last_fwd_ff  <= last_fwd_in;
         last_turn_ff <= last_turn_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_fwd_ff     <= s1_fwd_in;
      s1_twist_ff   <= s1_twist_in;
      s1_restart_ff <= s1_restart_in;
      out_fwd_ff    <= out_fwd_in;
      out_turn_ff   <= out_turn_in;
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.forward_drive = out_fwd_ff;
   assign rsp_ch.turn_drive    = out_turn_ff;
endmodule

// File: src/jds_axis.sv
module jds_axis import jds_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] prev,
   input  logic        [SAMPLE_BITS-2:0] deadband,
   input  logic        [SAMPLE_BITS-2:0] minimum,
   input  logic        [SAMPLE_BITS-2:0] step,
   output logic signed [SAMPLE_BITS-1:0] drive
);
   localparam int W    = SAMPLE_BITS;
   localparam int FRAC = SAMPLE_BITS - 1;
   localparam logic [2*W-1:0] RND = (2*W)'(1) << (FRAC - 1);

   logic                neg;
   logic [W-1:0]        mag;
   logic [2*W-1:0]      sq;
   logic [2*W-1:0]      sq_rnd;
   logic [W:0]          q;
   logic [FRAC-1:0]     q_sat;
   logic [FRAC-1:0]     mag_shaped;
   logic signed [W-1:0] shaped;
   logic signed [W:0]   shaped_x;
   logic signed [W:0]   prev_x;
   logic signed [W:0]   step_x;
   logic signed [W:0]   lim;

   assign neg    = sample[W-1];
   assign mag    = neg ? (W)'(-sample) : sample;
   assign sq     = {{W{1'b0}}, mag} * {{W{1'b0}}, mag};
   assign sq_rnd = sq + RND;
   assign q      = sq_rnd[2*W-1:FRAC];
   // only the most negative input squares past full scale
   assign q_sat  = (q[W:FRAC] != '0) ? {FRAC{1'b1}} : q[FRAC-1:0];

   always_comb begin
      priority if (q_sat <= deadband) begin
         mag_shaped = '0;
      end else if (q_sat < minimum) begin
         mag_shaped = minimum;
      end else begin
         mag_shaped = q_sat;
      end
   end

   assign shaped   = neg ? -$signed({1'b0, mag_shaped}) : $signed({1'b0, mag_shaped});
   assign shaped_x = $signed({shaped[W-1], shaped});
   assign prev_x   = $signed({prev[W-1], prev});
   assign step_x   = $signed({2'b00, step});

   // result stays between prev and shaped, so truncation is safe
   always_comb begin
      priority if (prev_x - shaped_x > step_x) begin
         lim = prev_x - step_x;
      end else if (shaped_x - prev_x > step_x) begin
         lim = prev_x + step_x;
      end else begin
         lim = shaped_x;
      end
   end

   assign drive = lim[W-1:0];
endmodule

// File: src/jds_checker.sv
`include "joystick_drive_shaper_defines.svh"

module jds_checker import jds_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] forward_drive,
   input logic [SAMPLE_BITS-1:0] turn_drive
);
   // a stalled result holds still
   `JDS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(forward_drive) && $stable(turn_drive))

   `JDS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // rsp_valid is high once a sample transfer has passed the input and result registers
   `JDS_ASSERT(a_latency, clock, reset, req_valid && req_ready |=> ##1 rsp_valid)

   // input side only backs up when the output is full and stalled
   `JDS_ASSERT(a_ready_low, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)
endmodule

bind joystick_drive_shaper jds_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_jds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .forward_drive (rsp_ch.forward_drive),
   .turn_drive    (rsp_ch.turn_drive)
);
